>>> sv/dib_pkg.sv
// ============================================================================
// dib_pkg
// Shared types and constants for the debounced digital input block.
// ============================================================================
package dib_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam int PIN_WIDTH       = 8;
    localparam int FILTER_WIDTH    = 16;
    localparam int CODE_WIDTH      = 8;
    localparam int FLAG_WIDTH      = 32;
    localparam int FUNC_COUNT      = 32;
    localparam int FUNC_PER_WORD   = 16;
    localparam int POS_WIDTH       = 4;
    localparam int CFG_IDX_WIDTH   = 2;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [FLAG_WIDTH-1:0] ODD_MASK      = 32'hAAAA_AAAA;
    localparam logic [POS_WIDTH-1:0]  CODE_LOW_MASK = 4'hF;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_POLARITY = 2'd0,
        CFG_FILTER   = 2'd1,
        CFG_FUNC_MAP = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 hit;
        logic                 grp;
        logic [POS_WIDTH-1:0] pos;
    } t_hit;

    typedef struct packed {
        logic [PIN_WIDTH-1:0]  levels;
        logic [FLAG_WIDTH-1:0] flags_lo;
        logic [FLAG_WIDTH-1:0] flags_hi;
    } t_result;

endpackage

>>> sv/dib_in_if.sv
// ============================================================================
// dib_in_if
// Raw pin sample channel.
// ============================================================================
interface dib_in_if;
    logic                           valid;
    logic                           ready;
    logic [dib_pkg::PIN_WIDTH-1:0]  raw_pins;

    modport source (output valid, output raw_pins, input ready);
    modport sink   (input valid, input raw_pins, output ready);
endinterface

>>> sv/dib_out_if.sv
// ============================================================================
// dib_out_if
// Debounced level and function flag channel.
// ============================================================================
interface dib_out_if;
    logic                           valid;
    logic                           ready;
    logic [dib_pkg::PIN_WIDTH-1:0]  filtered_levels;
    logic [dib_pkg::FLAG_WIDTH-1:0] function_flags_low;
    logic [dib_pkg::FLAG_WIDTH-1:0] function_flags_high;

    modport source (output valid, output filtered_levels, output function_flags_low,
                    output function_flags_high, input ready);
    modport sink   (input valid, input filtered_levels, input function_flags_low,
                    input function_flags_high, output ready);
endinterface

>>> sv/dib_lane.sv
// ============================================================================
// dib_lane
// One channel: active/inactive debounce counters, held level, code decode.
// ============================================================================
module dib_lane #(
    parameter int COUNT_WIDTH = dib_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_sample,
    input  logic [COUNT_WIDTH-1:0]          i_limit,
    input  logic [dib_pkg::CODE_WIDTH-1:0]  i_code,
    output logic                            o_level,
    output dib_pkg::t_hit                   o_hit
);

    logic [COUNT_WIDTH-1:0] r_act_cnt;
    logic [COUNT_WIDTH-1:0] r_inact_cnt;
    logic                   r_level;
    logic [COUNT_WIDTH-1:0] n_act_cnt;
    logic [COUNT_WIDTH-1:0] n_inact_cnt;
    logic                   w_pass;

    always_comb begin
        n_act_cnt   = r_act_cnt;
        n_inact_cnt = r_inact_cnt;
        w_pass      = 1'b1;
        if (i_sample) begin
            n_inact_cnt = '0;
            if (r_act_cnt < i_limit) begin
                n_act_cnt = r_act_cnt + 1'b1;
                w_pass    = 1'b0;
            end
        end else begin
            n_act_cnt = '0;
            if (r_inact_cnt < i_limit) begin
                n_inact_cnt = r_inact_cnt + 1'b1;
                w_pass      = 1'b0;
            end
        end
        o_level   = w_pass ? i_sample : r_level;
        o_hit.hit = o_level && (i_code != '0) &&
                    (i_code[dib_pkg::CODE_WIDTH-1:dib_pkg::POS_WIDTH+1] == '0);
        o_hit.grp = i_code[dib_pkg::POS_WIDTH];
        o_hit.pos = i_code[dib_pkg::POS_WIDTH-1:0] & dib_pkg::CODE_LOW_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_cnt   <= '0;
            r_inact_cnt <= '0;
            r_level     <= 1'b0;
        end else if (i_en) begin
            r_act_cnt   <= n_act_cnt;
            r_inact_cnt <= n_inact_cnt;
            r_level     <= o_level;
        end
    end

endmodule

>>> sv/dib_merge.sv
// ============================================================================
// dib_merge
// OR the lane hits into the flag words and keep the previous tick's flags.
// ============================================================================
module dib_merge #(
    parameter int NUM_CHANNELS = dib_pkg::NUM_CHANNELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [NUM_CHANNELS-1:0] i_levels,
    input  dib_pkg::t_hit           i_hits [NUM_CHANNELS],
    output dib_pkg::t_result        o_result
);

    logic [dib_pkg::FLAG_WIDTH-1:0] r_flags_lo;
    logic [dib_pkg::FLAG_WIDTH-1:0] r_flags_hi;
    logic [dib_pkg::FUNC_COUNT-1:0] w_active;
    logic [dib_pkg::FLAG_WIDTH-1:0] w_even_lo;
    logic [dib_pkg::FLAG_WIDTH-1:0] w_even_hi;

    always_comb begin
        w_active = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (i_hits[i].hit) begin
                w_active[{i_hits[i].grp, i_hits[i].pos}] = 1'b1;
            end
        end
        w_even_lo = '0;
        w_even_hi = '0;
        for (int k = 0; k < dib_pkg::FUNC_PER_WORD; k++) begin
            w_even_lo[2*k] = w_active[k];
            w_even_hi[2*k] = w_active[dib_pkg::FUNC_PER_WORD + k];
        end
        o_result.levels   = dib_pkg::PIN_WIDTH'(i_levels);
        o_result.flags_lo = ((r_flags_lo << 1) & dib_pkg::ODD_MASK) | w_even_lo;
        o_result.flags_hi = ((r_flags_hi << 1) & dib_pkg::ODD_MASK) | w_even_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags_lo <= '0;
            r_flags_hi <= '0;
        end else if (i_en) begin
            r_flags_lo <= o_result.flags_lo;
            r_flags_hi <= o_result.flags_hi;
        end
    end

endmodule

>>> sv/digital_input_debounce_function_map.sv
// ============================================================================
// digital_input_debounce_function_map
// Debounced digital inputs with polarity and function flag mapping.
// ============================================================================
// One pin sample is accepted per clock cycle unless input stalls; its result goes
// to the output register, or to the skid register if that is full. All channels
// run as parallel lanes, each with its own pair of debounce counters, so the rate
// is set only by the output stage: a two-entry output buffer (output register
// plus skid register) keeps accepting while one result waits, and stalls input
// only when both are full. Configuration takes effect on the next accepted sample.
module digital_input_debounce_function_map #(
    parameter int NUM_CHANNELS = dib_pkg::NUM_CHANNELS_DEF,
    parameter int COUNT_WIDTH  = dib_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dib_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [dib_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    dib_in_if.sink                              i_pins,
    dib_out_if.source                           o_result
);

    localparam logic [dib_pkg::FILTER_WIDTH-1:0] COUNT_MAX =
        dib_pkg::FILTER_WIDTH'((1 << COUNT_WIDTH) - 1);

    logic [dib_pkg::PIN_WIDTH-1:0]      r_polarity;
    logic [dib_pkg::FILTER_WIDTH-1:0]   r_filter;
    logic [dib_pkg::CFG_DATA_WIDTH-1:0] r_func_map;

    logic                   r_out_valid;
    logic                   r_skid_valid;
    dib_pkg::t_result       r_out_data;
    dib_pkg::t_result       r_skid_data;
    logic                   n_out_valid;
    logic                   n_skid_valid;
    dib_pkg::t_result       n_out_data;
    dib_pkg::t_result       n_skid_data;

    logic                          w_in_acc;
    logic                          w_out_take;
    logic [dib_pkg::PIN_WIDTH-1:0] w_logic;
    logic [COUNT_WIDTH-1:0]        w_limit;
    logic [NUM_CHANNELS-1:0]       w_levels;
    dib_pkg::t_hit                 w_hits [NUM_CHANNELS];
    dib_pkg::t_result              w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity <= '0;
            r_filter   <= '0;
            r_func_map <= '0;
        end else if (i_cfg_we) begin
            case (dib_pkg::t_cfg_idx'(i_cfg_idx))
                dib_pkg::CFG_POLARITY: begin
                    r_polarity <= i_cfg_data[dib_pkg::PIN_WIDTH-1:0];
                end
                dib_pkg::CFG_FILTER: begin
                    r_filter <= i_cfg_data[dib_pkg::FILTER_WIDTH-1:0];
                end
                dib_pkg::CFG_FUNC_MAP: begin
                    r_func_map <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign i_pins.ready = !r_skid_valid;
    assign w_in_acc     = i_pins.valid && !r_skid_valid;
    assign w_out_take   = r_out_valid && o_result.ready;
    assign w_logic      = ~(i_pins.raw_pins ^ r_polarity);
    assign w_limit      = (r_filter > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX)
                                                 : COUNT_WIDTH'(r_filter);

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
        dib_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_in_acc),
            .i_sample (w_logic[g]),
            .i_limit  (w_limit),
            .i_code   (r_func_map[g*dib_pkg::CODE_WIDTH +: dib_pkg::CODE_WIDTH]),
            .o_level  (w_levels[g]),
            .o_hit    (w_hits[g])
        );
    end

    dib_merge #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_in_acc),
        .i_levels (w_levels),
        .i_hits   (w_hits),
        .o_result (w_res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (w_out_take) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (w_in_acc) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_data  = w_res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.filtered_levels     = r_out_data.levels;
    assign o_result.function_flags_low  = r_out_data.flags_lo;
    assign o_result.function_flags_high = r_out_data.flags_hi;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_out_valid && !o_result.ready) |=> r_skid_valid)
        else $error("transaction accepted under stall not parked in skid");

    a_flag_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_rst_n) |=>
        ((w_res.flags_lo & dib_pkg::ODD_MASK) ==
         (($past(w_res.flags_lo) << 1) & dib_pkg::ODD_MASK)))
        else $error("odd flag bits do not track previous tick");
`endif

endmodule
